// ----- hdl/atrp_pkg.sv -----
// Package: shared types, constants and the arctangent table for the tilt block.
`timescale 1ns / 1ps
package atrp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int TABLE_LEN           = 24;
    localparam int ACC_FRAC            = 24;

    // Square of a 13-bit value is at most 2^24; a sum of two fits 26 bits.
    localparam int MAG2_W  = 26;
    // Radicand is mag2 << 16 (42 bits); root fits 21 bits.
    localparam int RAD_W   = 42;
    localparam int ROOT_W  = 21;
    // CORDIC working width: x grows to about 1.65 * 2^21, keep headroom.
    localparam int CW      = 25;
    // Angle accumulator, degrees * 2^24, |z| < 2^31.
    localparam int ZW      = 32;

    typedef struct packed {
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] z_low;
        logic [7:0] z_high;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic               undefined_flag;
    } out_word_t;

    // Per-angle side-band that travels alongside the CORDIC data.
    typedef struct packed {
        logic neg;     // numerator negative
        logic zden;    // denominator zero
        logic znum;    // numerator zero
    } ang_ctl_t;

    function automatic logic [ZW-1:0] atan_tab(input int i);
        logic [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = 32'd754974720;
            1:  r = 32'd445687602;
            2:  r = 32'd235489088;
            3:  r = 32'd119537938;
            4:  r = 32'd60000935;
            5:  r = 32'd30029717;
            6:  r = 32'd15018523;
            7:  r = 32'd7509720;
            8:  r = 32'd3754917;
            9:  r = 32'd1877466;
            10: r = 32'd938734;
            11: r = 32'd469367;
            12: r = 32'd234684;
            13: r = 32'd117342;
            14: r = 32'd58671;
            15: r = 32'd29335;
            16: r = 32'd14668;
            17: r = 32'd7334;
            18: r = 32'd3667;
            19: r = 32'd1833;
            20: r = 32'd917;
            21: r = 32'd458;
            22: r = 32'd229;
            23: r = 32'd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [12:0] sext13(input logic [7:0] lo, input logic [7:0] hi);
        return $signed({hi[4:0], lo});
    endfunction

endpackage

// ----- hdl/atrp_sqrt_cell.sv -----
// One radix-4 step of a pipelined restoring square root, with a delay lane.
`timescale 1ns / 1ps
module atrp_sqrt_cell #(
    parameter int STEP  = 0,
    parameter int SIDEW = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld,
    input  logic [atrp_pkg::RAD_W-1:0]    rem,
    input  logic [atrp_pkg::ROOT_W-1:0]   root,
    input  logic [SIDEW-1:0]              side,
    output logic                          vld_o,
    output logic [atrp_pkg::RAD_W-1:0]    rem_o,
    output logic [atrp_pkg::ROOT_W-1:0]   root_o,
    output logic [SIDEW-1:0]              side_o
);
    localparam int SH = 2 * (atrp_pkg::ROOT_W - 1 - STEP);

    logic                         vld_reg;
    logic [atrp_pkg::RAD_W-1:0]   rem_reg, rem_next;
    logic [atrp_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [SIDEW-1:0]             side_reg;
    logic [atrp_pkg::RAD_W+1:0]   trial;

    // trial = (4*root + 1) << SH, root holds the bits found so far
    always_comb
    begin
        trial = ({{(atrp_pkg::RAD_W+2-atrp_pkg::ROOT_W-2){1'b0}}, root, 2'b01}) << SH;
        if ({2'b00, rem} >= trial)
        begin
            rem_next  = rem - trial[atrp_pkg::RAD_W-1:0];
            root_next = {root[atrp_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem;
            root_next = {root[atrp_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side;
    end

    assign vld_o  = vld_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;
endmodule

// ----- hdl/atrp_cordic_cell.sv -----
// One vectoring CORDIC stage with registered outputs and a side-band lane.
`timescale 1ns / 1ps
module atrp_cordic_cell #(
    parameter int STEP  = 0,
    parameter int SIDEW = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              vld,
    input  logic signed [atrp_pkg::CW-1:0]    x,
    input  logic signed [atrp_pkg::CW-1:0]    y,
    input  logic signed [atrp_pkg::ZW-1:0]    z,
    input  logic [SIDEW-1:0]                  side,
    output logic                              vld_o,
    output logic signed [atrp_pkg::CW-1:0]    x_o,
    output logic signed [atrp_pkg::CW-1:0]    y_o,
    output logic signed [atrp_pkg::ZW-1:0]    z_o,
    output logic [SIDEW-1:0]                  side_o
);
    localparam logic [atrp_pkg::ZW-1:0] ANG = atrp_pkg::atan_tab(STEP);

    logic                              vld_reg;
    logic signed [atrp_pkg::CW-1:0]    x_reg, y_reg, x_next, y_next;
    logic signed [atrp_pkg::ZW-1:0]    z_reg, z_next;
    logic signed [atrp_pkg::CW-1:0]    dx, dy;
    logic [SIDEW-1:0]                  side_reg;

    always_comb
    begin
        dx = y >>> STEP;
        dy = x >>> STEP;
        if (!y[atrp_pkg::CW-1])
        begin
            x_next = x + dx;
            y_next = y - dy;
            z_next = z + $signed(ANG);
        end
        else
        begin
            x_next = x - dx;
            y_next = y + dy;
            z_next = z - $signed(ANG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= side;
    end

    assign vld_o  = vld_reg;
    assign x_o    = x_reg;
    assign y_o    = y_reg;
    assign z_o    = z_reg;
    assign side_o = side_reg;
endmodule

// ----- hdl/accel_tilt_roll_pitch.sv -----
// Top level: accelerometer roll and pitch through a square-root and CORDIC cell chain.
`timescale 1ns / 1ps
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------------
//  sample  | start, busy, sample        | taken when start=1 and busy=0
//  result  | done, result               | done high one cycle, no back-pressure
//
//  One sample per cycle. The chain: one decode register, 21 square-root cells,
//  min(CORDIC_STAGES, table length) CORDIC cells, one rounding/output register.
//  busy is tied low: every cell hands its word on each cycle.
//  Reset clears only the valid lane; data registers are not reset.
//  The receiver cannot stall, so nothing in the chain ever holds.
module accel_tilt_roll_pitch #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = atrp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  atrp_pkg::in_word_t  sample,
    output logic                done,
    output atrp_pkg::out_word_t result
);
    localparam int NST   = (CORDIC_STAGES < atrp_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                                 : atrp_pkg::TABLE_LEN;
    localparam int RW    = atrp_pkg::ROOT_W;
    localparam int CW    = atrp_pkg::CW;
    localparam int ZW    = atrp_pkg::ZW;
    localparam int SHR   = atrp_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    // side lane: per angle {ctl(3), |num|(13)}
    localparam int SIDEW = 2 * (3 + 13);

    assign busy = 1'b0;

    // ---------------- decode stage ----------------
    logic signed [12:0] xs, ys, zs;
    logic signed [13:0] pnum;           // -x can reach 4096
    logic signed [atrp_pkg::MAG2_W-1:0] xw, yw, zw;
    logic [atrp_pkg::MAG2_W-1:0] mr, mp;
    atrp_pkg::ang_ctl_t cr, cp;
    logic [12:0] ar, ap;

    always_comb
    begin
        xs   = atrp_pkg::sext13(sample.x_low, sample.x_high);
        ys   = atrp_pkg::sext13(sample.y_low, sample.y_high);
        zs   = atrp_pkg::sext13(sample.z_low, sample.z_high);
        xw   = atrp_pkg::MAG2_W'(xs);
        yw   = atrp_pkg::MAG2_W'(ys);
        zw   = atrp_pkg::MAG2_W'(zs);
        pnum = -{xs[12], xs};
        // squares are at most 2^24, so each sum stays below 2^26
        mr   = $unsigned(xw * xw) + $unsigned(zw * zw);
        mp   = $unsigned(yw * yw) + $unsigned(zw * zw);
        cr.neg  = ys[12];
        cr.znum = (ys == '0);
        cr.zden = (mr == '0);
        cp.neg  = pnum[13];
        cp.znum = (xs == '0);
        cp.zden = (mp == '0);
        ar = ys[12] ? 13'(-ys) : 13'(ys);
        ap = xs[12] ? 13'(-xs) : 13'(xs);
    end

    logic                            d_vld_reg;
    logic [atrp_pkg::MAG2_W-1:0]     d_mr_reg, d_mp_reg;
    logic [SIDEW-1:0]                d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        d_mr_reg   <= mr;
        d_mp_reg   <= mp;
        d_side_reg <= {cr, ar, cp, ap};
    end

    // ---------------- square-root cell chain, two lanes ----------------
    logic [RW:0]                   s_vld;
    logic [RW:0][atrp_pkg::RAD_W-1:0] s_rem_r, s_rem_p;
    logic [RW:0][RW-1:0]           s_root_r, s_root_p;
    logic [RW:0][SIDEW-1:0]        s_side;
    logic [RW:0]                   s_vld_p;
    logic [RW:0][SIDEW-1:0]        s_side_p;

    assign s_vld[0]    = d_vld_reg;
    assign s_vld_p[0]  = d_vld_reg;
    assign s_rem_r[0]  = {d_mr_reg, 16'd0};
    assign s_rem_p[0]  = {d_mp_reg, 16'd0};
    assign s_root_r[0] = '0;
    assign s_root_p[0] = '0;
    assign s_side[0]   = d_side_reg;
    assign s_side_p[0] = '0;

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        atrp_sqrt_cell #(.STEP(g), .SIDEW(SIDEW)) u_r (
            .clk(clk), .rst_n(rst_n), .vld(s_vld[g]), .rem(s_rem_r[g]),
            .root(s_root_r[g]), .side(s_side[g]), .vld_o(s_vld[g+1]),
            .rem_o(s_rem_r[g+1]), .root_o(s_root_r[g+1]), .side_o(s_side[g+1])
        );
        atrp_sqrt_cell #(.STEP(g), .SIDEW(SIDEW)) u_p (
            .clk(clk), .rst_n(rst_n), .vld(s_vld_p[g]), .rem(s_rem_p[g]),
            .root(s_root_p[g]), .side(s_side_p[g]), .vld_o(s_vld_p[g+1]),
            .rem_o(s_rem_p[g+1]), .root_o(s_root_p[g+1]), .side_o(s_side_p[g+1])
        );
    end

    // ---------------- CORDIC cell chain, two lanes ----------------
    logic [NST:0]                  c_vld, c_vld_p;
    logic signed [NST:0][CW-1:0]   c_xr, c_yr, c_xp, c_yp;
    logic signed [NST:0][ZW-1:0]   c_zr, c_zp;
    logic [NST:0][SIDEW-1:0]       c_side, c_side_p;

    assign c_vld[0]    = s_vld[RW];
    assign c_vld_p[0]  = s_vld_p[RW];
    assign c_xr[0]     = CW'(s_root_r[RW]);
    assign c_xp[0]     = CW'(s_root_p[RW]);
    assign c_yr[0]     = CW'({s_side[RW][28:16], 8'd0});
    assign c_yp[0]     = CW'({s_side[RW][12:0], 8'd0});
    assign c_zr[0]     = '0;
    assign c_zp[0]     = '0;
    assign c_side[0]   = s_side[RW];
    assign c_side_p[0] = s_side_p[RW];

    for (genvar g = 0; g < NST; g++)
    begin : g_cordic
        atrp_cordic_cell #(.STEP(g), .SIDEW(SIDEW)) u_r (
            .clk(clk), .rst_n(rst_n), .vld(c_vld[g]), .x(c_xr[g]), .y(c_yr[g]),
            .z(c_zr[g]), .side(c_side[g]), .vld_o(c_vld[g+1]), .x_o(c_xr[g+1]),
            .y_o(c_yr[g+1]), .z_o(c_zr[g+1]), .side_o(c_side[g+1])
        );
        atrp_cordic_cell #(.STEP(g), .SIDEW(SIDEW)) u_p (
            .clk(clk), .rst_n(rst_n), .vld(c_vld_p[g]), .x(c_xp[g]), .y(c_yp[g]),
            .z(c_zp[g]), .side(c_side_p[g]), .vld_o(c_vld_p[g+1]), .x_o(c_xp[g+1]),
            .y_o(c_yp[g+1]), .z_o(c_zp[g+1]), .side_o(c_side_p[g+1])
        );
    end

    // ---------------- rounding, special cases, output register ----------------
    function automatic logic signed [15:0] finish(input logic signed [ZW-1:0] z,
                                                  input atrp_pkg::ang_ctl_t c);
        logic signed [ZW:0] q;
        logic signed [ZW:0] rt;
        q  = ($signed({z[ZW-1], z}) + (ZW+1)'(1 << (SHR - 1))) >>> SHR;
        rt = (ZW+1)'(90 << ANGLE_FRAC_BITS);
        if (c.zden)
            q = c.znum ? '0 : (c.neg ? -rt : rt);
        else if (c.znum)
            q = '0;
        else if (c.neg)
            q = -q;
        if (q > 32767)
            return 16'sh7fff;
        if (q < -32768)
            return 16'sh8000;
        return q[15:0];
    endfunction

    atrp_pkg::ang_ctl_t fr, fp;
    logic               o_vld_reg;
    atrp_pkg::out_word_t o_reg;

    assign fr = c_side[NST][31:29];
    assign fp = c_side[NST][15:13];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else
            o_vld_reg <= c_vld[NST];
    end

    always_ff @(posedge clk)
    begin
        o_reg.roll_angle     <= finish(c_zr[NST], fr);
        o_reg.pitch_angle    <= finish(c_zp[NST], fp);
        o_reg.undefined_flag <= (fr.zden & fr.znum) | (fp.zden & fp.znum);
    end

    assign done   = o_vld_reg;
    assign result = o_reg;

    // both lanes move in lockstep
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld[NST] == c_vld_p[NST]) else $error("lane valid mismatch");
    // square-root chain valid is start delayed by the decode register and root cells
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_vld[RW] |-> $past(start, RW + 1)) else $error("sqrt chain latency");
    // busy never asserted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy asserted");
    // undefined flag only with a zero roll angle
    a_undef: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.undefined_flag |-> result.roll_angle == 16'sd0)
        else $error("undefined with nonzero roll");
endmodule

// ----- verif/accel_tilt_roll_pitch_tb.sv -----
// Testbench for the accelerometer roll and pitch block: directed and random samples.
`timescale 1ns / 1ps
module accel_tilt_roll_pitch_tb;

    localparam int FRAC    = 8;
    localparam int STAGES  = 16;
    // decode + root cells + CORDIC cells + output register; slack is added where used
    localparam int LATENCY = 1 + 21 + STAGES + 1;
    localparam int N_RAND  = 1650;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    atrp_pkg::in_word_t  sample;
    logic                done;
    atrp_pkg::out_word_t result;

    accel_tilt_roll_pitch #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample(sample), .done(done), .result(result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    atrp_pkg::in_word_t  pending_words[$];
    atrp_pkg::out_word_t expected_angles[$];
    int        idle_pct;
    bit        hold_for_drain;
    int        mismatches;

    // arctangent of 2^-i, degrees * 2^24
    function automatic longint atan_step(input int i);
        longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000935,
                          30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                          469367, 234684, 117342, 58671, 29335, 14668, 7334,
                          3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic longint axis_value(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [12:0] v;
        v = {hi[4:0], lo};
        return longint'(v);
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // atan(num / sqrt(a^2 + b^2)) in degrees * 2^FRAC
    function automatic longint tilt_deg(input longint num, input longint a,
                                        input longint b, inout bit undef);
        longint m2, x, y, z, dx, dy, q, right;
        m2 = a * a + b * b;
        right = 64'sd90 <<< FRAC;
        z = 0;
        if (m2 == 0)
        begin
            if (num == 0)
            begin
                undef = 1'b1;
                return 0;
            end
            return clamp16(num > 0 ? right : -right);
        end
        if (num == 0) return 0;
        x = int_sqrt(m2 <<< 16);
        y = (num < 0 ? -num : num) * 256;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = y >>> i;   // arithmetic shift floors
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        q = (z + (64'sd1 <<< (23 - FRAC))) >>> (24 - FRAC);
        if (num < 0) q = -q;
        return clamp16(q);
    endfunction

    function automatic atrp_pkg::out_word_t predict_tilt(input atrp_pkg::in_word_t w);
        atrp_pkg::out_word_t r;
        longint ax, ay, az;
        bit undef;
        undef = 1'b0;
        ax = axis_value(w.x_low, w.x_high);
        ay = axis_value(w.y_low, w.y_high);
        az = axis_value(w.z_low, w.z_high);
        r.roll_angle     = 16'(tilt_deg(ay, ax, az, undef));
        r.pitch_angle    = 16'(tilt_deg(-ax, ay, az, undef));
        r.undefined_flag = undef;
        return r;
    endfunction

    function automatic atrp_pkg::in_word_t axes_word(input int ax, input int ay,
                                                     input int az);
        atrp_pkg::in_word_t w;
        logic [12:0] vx, vy, vz;
        vx = 13'(ax); vy = 13'(ay); vz = 13'(az);
        // upper three high-byte bits are random: the block must ignore them
        w.x_low = vx[7:0]; w.x_high = {3'($urandom), vx[12:8]};
        w.y_low = vy[7:0]; w.y_high = {3'($urandom), vy[12:8]};
        w.z_low = vz[7:0]; w.z_high = {3'($urandom), vz[12:8]};
        return w;
    endfunction

    // driver: one word per accepted edge, change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy)
        begin
            // word taken at the last rising edge; present the next one or idle
            expected_angles.push_back(predict_tilt(sample));
            void'(pending_words.pop_front());
            if (pending_words.size() != 0 && !hold_for_drain
                && $urandom_range(99) >= idle_pct)
            begin
                sample <= pending_words[0];
                start  <= 1'b1;
            end
            else
                start <= 1'b0;
        end
        else if (!start && pending_words.size() != 0 && !hold_for_drain
                 && $urandom_range(99) >= idle_pct)
        begin
            sample <= pending_words[0];
            start  <= 1'b1;
        end
    end

    // monitor: compare every strobed word with the oldest prediction
    always @(posedge clk)
    begin
        atrp_pkg::out_word_t exp_w;
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word roll=%0d pitch=%0d undef=%0b",
                             result.roll_angle, result.pitch_angle,
                             result.undefined_flag);
            end
            else
            begin
                exp_w = expected_angles.pop_front();
                if (result !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp roll=%0d pitch=%0d undef=%0b,",
                                  " got roll=%0d pitch=%0d undef=%0b"},
                                 exp_w.roll_angle, exp_w.pitch_angle,
                                 exp_w.undefined_flag, result.roll_angle,
                                 result.pitch_angle, result.undefined_flag);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || start || expected_angles.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ex[4];
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        idle_pct = 33;
        hold_for_drain = 1'b0;
        mismatches = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: all-zero, zero denominators, zero numerators, extremes
        pending_words.push_back('0);
        pending_words.push_back(axes_word(0, 100, 0));
        pending_words.push_back(axes_word(0, -100, 0));
        pending_words.push_back(axes_word(100, 0, 0));
        pending_words.push_back(axes_word(-100, 0, 0));
        pending_words.push_back(axes_word(0, 0, 4095));
        pending_words.push_back(axes_word(0, 0, -4096));
        pending_words.push_back(axes_word(4095, 4095, 4095));
        pending_words.push_back(axes_word(-4096, -4096, -4096));
        pending_words.push_back(axes_word(-4096, 4095, 0));
        pending_words.push_back(axes_word(4095, -4096, 1));
        pending_words.push_back(axes_word(1, -1, 0));
        pending_words.push_back(axes_word(-1, 1, 1));
        pending_words.push_back(axes_word(0, 0, 1));
        pending_words.push_back(axes_word(256, 256, 256));
        pending_words.push_back({48{1'b1}});
        pending_words.push_back({6{8'h55}});
        pending_words.push_back({6{8'haa}});

        // pressure: let everything drain before the random part
        wait_drained();
        hold_for_drain = 1'b1;
        repeat (LATENCY + 4) @(posedge clk);
        hold_for_drain = 1'b0;

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 33 : (phase == 1) ? 58 : 0;
            for (int n = 0; n < N_RAND / 3; n++)
            begin
                case ($urandom_range(3))
                    0: pending_words.push_back(
                           atrp_pkg::in_word_t'(48'({$urandom, $urandom})));
                    1:
                    begin
                        // small values on two axes, one axis dominant
                        for (int k = 0; k < 3; k++)
                            ex[k] = $urandom_range(40) - 20;
                        ex[$urandom_range(2)] = $urandom_range(1) ? 256 : -256;
                        pending_words.push_back(axes_word(ex[0], ex[1], ex[2]));
                    end
                    2:
                    begin
                        // each axis is zero with a one-in-three chance
                        for (int k = 0; k < 3; k++)
                            ex[k] = $urandom_range(2) == 0 ? 0
                                    : int'($urandom_range(8191)) - 4096;
                        pending_words.push_back(axes_word(ex[0], ex[1], ex[2]));
                    end
                    default:
                    begin
                        for (int k = 0; k < 3; k++)
                            ex[k] = int'($urandom_range(8191)) - 4096;
                        pending_words.push_back(axes_word(ex[0], ex[1], ex[2]));
                    end
                endcase
            end
            wait_drained();
        end

        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
